// ===== rtl/sha1mh_pkg.sv =====
`default_nettype none
// ============================================================================
// sha1mh_pkg: shared types and constants of the SHA-1 message hasher
// Holds the working-variable record, the initial chaining values, the round
// constants and the fixed counts of the block and padding layout.
// ============================================================================
package sha1mh_pkg;

    // Five working variables of the compression function.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    // Chaining values loaded at reset and after each finished message.
    localparam logic [31:0] H_INIT [0:4] = '{
        32'h67452301,
        32'hEFCDAB89,
        32'h98BADCFE,
        32'h10325476,
        32'hC3D2E1F0
    };

    // Round constants, one for each group of twenty rounds.
    localparam logic [31:0] K_ROUND [0:3] = '{
        32'h5A827999,
        32'h6ED9EBA1,
        32'h8F1BBCDC,
        32'hCA62C1D6
    };

    // Round groups.
    localparam logic [1:0] PH_CHOOSE = 2'd0;
    localparam logic [1:0] PH_PARITY = 2'd1;
    localparam logic [1:0] PH_MAJOR  = 2'd2;
    localparam logic [1:0] PH_PARITY2 = 2'd3;

    localparam int unsigned BLOCK_BITS = 512;
    localparam int unsigned WORD_COUNT = 5;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [5:0]  LAST_POS   = 6'd63;
    // Byte position where the 64-bit length field begins (448 bits).
    localparam logic [5:0]  LEN_POS    = 6'd56;
    localparam logic [3:0]  LEN_BYTES  = 4'd8;
    localparam logic [7:0]  PAD_MARK   = 8'h80;

endpackage : sha1mh_pkg
`default_nettype wire

// ===== rtl/sha1mh_round.sv =====
`default_nettype none
// ============================================================================
// sha1mh_round: one SHA-1 round and one message schedule step
// Combines the working variables with the current schedule word and the
// group's logic function and constant, and forms the next schedule word.
// ============================================================================
module sha1mh_round (
    input  wire sha1mh_pkg::t_work i_work,
    input  wire logic [1:0]        i_phase,
    input  wire logic [31:0]       i_w0,
    input  wire logic [31:0]       i_w2,
    input  wire logic [31:0]       i_w8,
    input  wire logic [31:0]       i_w13,
    output sha1mh_pkg::t_work      o_work,
    output logic [31:0]            o_w_next
);
    import sha1mh_pkg::*;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] w_mix;
    logic [31:0] tmp;

    // Logic function and constant of the current round group.
    always_comb begin
        case (i_phase)
            PH_CHOOSE: begin
                f_val = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            end
            PH_MAJOR: begin
                f_val = (i_work.b & i_work.c) | (i_work.b & i_work.d) |
                        (i_work.c & i_work.d);
            end
            default: begin
                f_val = i_work.b ^ i_work.c ^ i_work.d;
            end
        endcase
        k_val = K_ROUND[i_phase];
    end

    // Round sum and rotation of the working variables.
    assign tmp = {i_work.a[26:0], i_work.a[31:27]} + f_val + i_work.e + k_val + i_w0;

    always_comb begin
        o_work.a = tmp;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

    // Schedule word sixteen places ahead of the current one.
    assign w_mix    = i_w13 ^ i_w8 ^ i_w2 ^ i_w0;
    assign o_w_next = {w_mix[30:0], w_mix[31]};

endmodule : sha1mh_round
`default_nettype wire

// ===== rtl/sha1_message_hasher.sv =====
`default_nettype none
// ============================================================================
// sha1_message_hasher: streaming SHA-1 message digest
// Message bytes in, five big-endian 32-bit digest words out per message.
// ============================================================================
// Each input request carries one optional message byte (tuser) and an end of
// message flag (tlast). A request is taken whenever the hasher is idle; the byte
// that fills a 64-byte block starts the compression, which runs all rounds on a
// single round unit and then folds the result into the chaining words; the input
// is not ready until that fold is done. An end of message pads the message one
// byte per cycle, except while a compression runs, through the same byte shifter
// (0x80, zeros, the 64-bit bit length), running one or two compressions, then
// presents the five digest words H0 to H4 as five output requests; the input is
// not ready again until the fifth word is taken, after which the hasher starts a
// new message.
// ============================================================================
module sha1_message_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  i_s_tuser,   // [0] byte_valid
    input  wire logic        i_s_tlast,   // end_of_message
    // Digest stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] digest_word
    output logic [2:0]       o_m_tuser,   // [2:0] word_index
    output logic             o_m_tlast    // last_word
);
    import sha1mh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [2:0] LAST_IDX = 3'(WORD_COUNT - 1);

    // Control state.
    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [60:0] r_count, n_count;
    logic [6:0]  r_rnd, n_rnd;
    logic        r_fin, n_fin;
    logic        r_mark, n_mark;
    logic [3:0]  r_lencnt, n_lencnt;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_h [0:4];
    logic [31:0] n_h [0:4];

    // Payload state.
    logic [BLOCK_BITS-1:0] r_blk, n_blk;
    t_work                 r_work, n_work;
    logic [63:0]           r_len, n_len;

    // Byte shifter controls.
    logic        shift_en;
    logic [7:0]  shift_byte;

    // Round unit connections.
    logic [1:0]  phase;
    t_work       round_work;
    logic [31:0] w_next;

    logic s_acc;
    logic m_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = r_h[r_idx];
    assign o_m_tuser  = r_idx;
    assign o_m_tlast  = (r_idx == LAST_IDX);

    assign s_acc = i_s_tvalid & o_s_tready;
    assign m_acc = o_m_tvalid & i_m_tready;

    // Round group from the round counter.
    always_comb begin
        if (r_rnd < 7'd20) begin
            phase = PH_CHOOSE;
        end else if (r_rnd < 7'd40) begin
            phase = PH_PARITY;
        end else if (r_rnd < 7'd60) begin
            phase = PH_MAJOR;
        end else begin
            phase = PH_PARITY2;
        end
    end

    // Shared round unit; the block register doubles as the schedule window.
    sha1mh_round u_round (
        .i_work   (r_work),
        .i_phase  (phase),
        .i_w0     (r_blk[BLOCK_BITS-1      -: 32]),
        .i_w2     (r_blk[BLOCK_BITS-1-64   -: 32]),
        .i_w8     (r_blk[BLOCK_BITS-1-256  -: 32]),
        .i_w13    (r_blk[BLOCK_BITS-1-416  -: 32]),
        .o_work   (round_work),
        .o_w_next (w_next)
    );

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_count    = r_count;
        n_rnd      = r_rnd;
        n_fin      = r_fin;
        n_mark     = r_mark;
        n_lencnt   = r_lencnt;
        n_idx      = r_idx;
        n_blk      = r_blk;
        n_work     = r_work;
        n_len      = r_len;
        shift_en   = 1'b0;
        shift_byte = 8'h00;
        for (int i = 0; i < WORD_COUNT; i++) begin
            n_h[i] = r_h[i];
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser[0]) begin
                        shift_en   = 1'b1;
                        shift_byte = i_s_tdata;
                        n_count    = r_count + 61'd1;
                    end
                    if (i_s_tlast) begin
                        n_fin   = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // Marker byte, then zeros up to the length field, then length.
                shift_en = 1'b1;
                if (!r_mark) begin
                    shift_byte = PAD_MARK;
                    n_mark     = 1'b1;
                    n_len      = {r_count, 3'b000};
                end else if (r_lencnt == 4'd0 && r_pos != LEN_POS) begin
                    shift_byte = 8'h00;
                end else begin
                    shift_byte = r_len[63:56];
                    n_len      = {r_len[55:0], 8'h00};
                    n_lencnt   = r_lencnt + 4'd1;
                end
            end
            S_ROUND: begin
                n_work = round_work;
                n_blk  = {r_blk[BLOCK_BITS-33:0], w_next};
                n_rnd  = r_rnd + 7'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_h[0] = r_h[0] + r_work.a;
                n_h[1] = r_h[1] + r_work.b;
                n_h[2] = r_h[2] + r_work.c;
                n_h[3] = r_h[3] + r_work.d;
                n_h[4] = r_h[4] + r_work.e;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_lencnt == LEN_BYTES) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (m_acc) begin
                    if (r_idx == LAST_IDX) begin
                        // Digest delivered; start a fresh message.
                        n_idx    = 3'd0;
                        n_count  = '0;
                        n_fin    = 1'b0;
                        n_mark   = 1'b0;
                        n_lencnt = 4'd0;
                        n_state  = S_IDLE;
                        for (int i = 0; i < WORD_COUNT; i++) begin
                            n_h[i] = H_INIT[i];
                        end
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Byte shifter; a full block starts the compression.
        if (shift_en) begin
            n_blk = {r_blk[BLOCK_BITS-9:0], shift_byte};
            n_pos = r_pos + 6'd1;
            if (r_pos == LAST_POS) begin
                n_state = S_ROUND;
                n_rnd   = 7'd0;
                n_work  = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= 6'd0;
            r_count  <= '0;
            r_rnd    <= 7'd0;
            r_fin    <= 1'b0;
            r_mark   <= 1'b0;
            r_lencnt <= 4'd0;
            r_idx    <= 3'd0;
            for (int i = 0; i < WORD_COUNT; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_rnd    <= n_rnd;
            r_fin    <= n_fin;
            r_mark   <= n_mark;
            r_lencnt <= n_lencnt;
            r_idx    <= n_idx;
            for (int i = 0; i < WORD_COUNT; i++) begin
                r_h[i] <= n_h[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_work <= n_work;
        r_len  <= n_len;
    end

endmodule : sha1_message_hasher
`default_nettype wire
